// ----- hw/rtl/lpim_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpim_pkg
// Shared widths, codes and controller/datapath interface types for the
// linear probe id map.
// ----------------------------------------------------------------------------
package lpim_pkg;

    localparam int FUNC_W       = 2;
    localparam int KEY_FIELD_W  = 24;
    localparam int ID_FIELD_W   = 24;
    localparam int STATUS_W     = 2;
    localparam int TABLE_SIZE_W = 11;

    localparam int S_DATA_BITS  = FUNC_W + KEY_FIELD_W;
    localparam int S_TDATA_W    = ((S_DATA_BITS + 7) / 8) * 8;
    localparam int S_PAD_W      = S_TDATA_W - S_DATA_BITS;
    localparam int M_DATA_BITS  = STATUS_W + ID_FIELD_W + ID_FIELD_W;
    localparam int M_TDATA_W    = ((M_DATA_BITS + 7) / 8) * 8;
    localparam int M_PAD_W      = M_TDATA_W - M_DATA_BITS;

    localparam int CFG_INDEX_W  = 8;
    localparam int CFG_DATA_W   = 24;

    localparam logic [TABLE_SIZE_W-1:0] TABLE_SIZE_RESET = TABLE_SIZE_W'(1024);
    localparam logic [CFG_DATA_W-1:0]   FIRST_VALUE_RESET = '0;

    localparam logic [CFG_INDEX_W-1:0] REG_TABLE_SIZE  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_VALUE = 8'd1;

    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

    localparam logic [1:0] MAP_ZERO  = 2'd0;
    localparam logic [1:0] MAP_SLOT  = 2'd1;
    localparam logic [1:0] MAP_COUNT = 2'd2;

    typedef struct packed {
        logic                accept;
        logic                div_step;
        logic                probe_start;
        logic                probe_step;
        logic                ins_write;
        logic                sweep_start;
        logic                sweep_step;
        logic                clear_load;
        logic                res_load;
        logic [STATUS_W-1:0] res_status;
        logic [1:0]          res_sel;
        logic                push_out;
    } cmd_t;

    typedef struct packed {
        logic              div_last;
        logic              slot_empty;
        logic              slot_hit;
        logic              probe_last;
        logic              sweep_last;
        logic              out_free;
        logic [FUNC_W-1:0] cur_func;
    } stat_t;

endpackage

// ----- hw/rtl/lpim_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpim_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lpim_ram #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/lpim_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpim_datapath
// Config registers, key modulo divider, probe address and counters, slot
// memory, id counter and output register.
// ----------------------------------------------------------------------------
module lpim_datapath #(
    parameter int CAPACITY  = 1024,
    parameter int KEY_WIDTH = 24,
    parameter int ID_WIDTH  = 24
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  lpim_pkg::cmd_t                    cmd,
    output lpim_pkg::stat_t                   stat,
    input  logic [lpim_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lpim_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              cfg_valid,
    input  logic [lpim_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lpim_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int SIZE_W = $clog2(CAPACITY + 1);
    localparam int CNT_W  = $clog2(KEY_WIDTH + 1);
    localparam int RAM_W  = 1 + KEY_WIDTH + ID_WIDTH;

    logic [lpim_pkg::TABLE_SIZE_W-1:0] table_size_reg;
    logic [lpim_pkg::CFG_DATA_W-1:0]   first_value_reg;

    logic [lpim_pkg::FUNC_W-1:0] func_reg;
    logic [KEY_WIDTH-1:0]        key_reg;
    logic [SIZE_W-1:0]           size_reg;
    logic [KEY_WIDTH-1:0]        div_key_reg;
    logic [SIZE_W-1:0]           div_rem_reg;
    logic [SIZE_W-1:0]           div_rem_next;
    logic [CNT_W-1:0]            div_cnt_reg;
    logic [ADDR_W-1:0]           pos_reg;
    logic [ADDR_W-1:0]           pos_next;
    logic [SIZE_W-1:0]           probe_cnt_reg;
    logic [ADDR_W-1:0]           sweep_addr_reg;
    logic [ID_WIDTH-1:0]         counter_reg;

    logic [lpim_pkg::STATUS_W-1:0]   res_status_reg;
    logic [lpim_pkg::ID_FIELD_W-1:0] res_mapped_reg;
    logic [lpim_pkg::ID_FIELD_W-1:0] res_mapped_next;

    logic                            m_valid_reg;
    logic [lpim_pkg::STATUS_W-1:0]   m_status_reg;
    logic [lpim_pkg::ID_FIELD_W-1:0] m_mapped_reg;
    logic [lpim_pkg::ID_FIELD_W-1:0] m_next_id_reg;

    logic [SIZE_W-1:0]   size_use;
    logic [SIZE_W:0]     div_trial;
    logic [SIZE_W:0]     div_diff;
    logic [SIZE_W-1:0]   pos_inc;
    logic [SIZE_W-1:0]   cnt_inc;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [RAM_W-1:0]    ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [RAM_W-1:0]    ram_rdata;
    logic                slot_valid;
    logic [KEY_WIDTH-1:0] slot_key;
    logic [ID_WIDTH-1:0] slot_id;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_size_reg  <= lpim_pkg::TABLE_SIZE_RESET;
            first_value_reg <= lpim_pkg::FIRST_VALUE_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == lpim_pkg::REG_TABLE_SIZE) begin
                table_size_reg <= cfg_data[lpim_pkg::TABLE_SIZE_W-1:0];
            end else if (cfg_index == lpim_pkg::REG_FIRST_VALUE) begin
                first_value_reg <= cfg_data;
            end
        end
    end

    always_comb begin
        if (table_size_reg == '0) begin
            size_use = SIZE_W'(1);
        end else if (32'(table_size_reg) > 32'(CAPACITY)) begin
            size_use = SIZE_W'(CAPACITY);
        end else begin
            size_use = SIZE_W'(table_size_reg);
        end
    end

    // restoring remainder, one key bit per cycle
    assign div_trial    = {div_rem_reg, div_key_reg[KEY_WIDTH-1]};
    assign div_diff     = div_trial - {1'b0, size_reg};
    assign div_rem_next = (div_trial >= {1'b0, size_reg}) ? div_diff[SIZE_W-1:0]
                                                          : div_trial[SIZE_W-1:0];

    assign pos_inc  = SIZE_W'(pos_reg) + SIZE_W'(1);
    assign pos_next = (pos_inc == size_reg) ? '0 : pos_inc[ADDR_W-1:0];
    assign cnt_inc  = probe_cnt_reg + SIZE_W'(1);

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            func_reg    <= s_tdata[lpim_pkg::FUNC_W-1:0];
            key_reg     <= KEY_WIDTH'(s_tdata[lpim_pkg::FUNC_W +: lpim_pkg::KEY_FIELD_W]);
            div_key_reg <= KEY_WIDTH'(s_tdata[lpim_pkg::FUNC_W +: lpim_pkg::KEY_FIELD_W]);
            size_reg    <= size_use;
            div_rem_reg <= '0;
            div_cnt_reg <= CNT_W'(KEY_WIDTH);
        end else if (cmd.div_step) begin
            div_key_reg <= {div_key_reg[KEY_WIDTH-2:0], 1'b0};
            div_rem_reg <= div_rem_next;
            div_cnt_reg <= div_cnt_reg - CNT_W'(1);
        end
        if (cmd.probe_start) begin
            pos_reg       <= div_rem_reg[ADDR_W-1:0];
            probe_cnt_reg <= '0;
        end else if (cmd.probe_step) begin
            pos_reg       <= pos_next;
            probe_cnt_reg <= cnt_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_addr_reg <= '0;
        end else if (cmd.sweep_start) begin
            sweep_addr_reg <= '0;
        end else if (cmd.sweep_step) begin
            sweep_addr_reg <= sweep_addr_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_reg <= ID_WIDTH'(lpim_pkg::FIRST_VALUE_RESET);
        end else if (cmd.clear_load) begin
            counter_reg <= ID_WIDTH'(first_value_reg);
        end else if (cmd.ins_write) begin
            counter_reg <= counter_reg + ID_WIDTH'(1);
        end
    end

    // slot memory: valid, key, id
    assign ram_we    = cmd.sweep_step | cmd.ins_write;
    assign ram_waddr = cmd.sweep_step ? sweep_addr_reg : pos_reg;
    assign ram_wdata = cmd.sweep_step ? '0 : {1'b1, key_reg, counter_reg};
    assign ram_raddr = cmd.probe_start ? div_rem_reg[ADDR_W-1:0] : pos_next;

    lpim_ram #(
        .WIDTH (RAM_W),
        .DEPTH (CAPACITY)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign slot_valid = ram_rdata[RAM_W-1];
    assign slot_key   = ram_rdata[ID_WIDTH +: KEY_WIDTH];
    assign slot_id    = ram_rdata[ID_WIDTH-1:0];

    always_comb begin
        case (cmd.res_sel)
            lpim_pkg::MAP_SLOT:  res_mapped_next = lpim_pkg::ID_FIELD_W'(slot_id);
            lpim_pkg::MAP_COUNT: res_mapped_next = lpim_pkg::ID_FIELD_W'(counter_reg);
            default:             res_mapped_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            res_status_reg <= cmd.res_status;
            res_mapped_reg <= res_mapped_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.push_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push_out) begin
            m_status_reg  <= res_status_reg;
            m_mapped_reg  <= res_mapped_reg;
            m_next_id_reg <= lpim_pkg::ID_FIELD_W'(counter_reg);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{lpim_pkg::M_PAD_W{1'b0}}, m_next_id_reg, m_mapped_reg, m_status_reg};

    assign stat.div_last   = (div_cnt_reg == CNT_W'(1));
    assign stat.slot_empty = ~slot_valid;
    assign stat.slot_hit   = slot_valid & (slot_key == key_reg);
    assign stat.probe_last = (cnt_inc == size_reg);
    assign stat.sweep_last = (sweep_addr_reg == ADDR_W'(CAPACITY - 1));
    assign stat.out_free   = ~m_valid_reg | m_tready;
    assign stat.cur_func   = func_reg;

endmodule

// ----- hw/rtl/lpim_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpim_ctrl
// Sequencer: init sweep, divide, probe walk, clear sweep, result hand-off.
// ----------------------------------------------------------------------------
module lpim_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [lpim_pkg::FUNC_W-1:0] s_func,
    input  lpim_pkg::stat_t             stat,
    output lpim_pkg::cmd_t              cmd
);

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_ISSUE = 3'd3;
    localparam logic [2:0] ST_CHECK = 3'd4;
    localparam logic [2:0] ST_SWEEP = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    case (s_func)
                        lpim_pkg::FUNC_LOOKUP,
                        lpim_pkg::FUNC_INSERT: begin
                            state_next = ST_DIV;
                        end
                        lpim_pkg::FUNC_CLEAR: begin
                            cmd.sweep_start = 1'b1;
                            state_next      = ST_SWEEP;
                        end
                        default: begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = lpim_pkg::STAT_OK;
                            cmd.res_sel    = lpim_pkg::MAP_ZERO;
                            state_next     = ST_DONE;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                cmd.probe_start = 1'b1;
                state_next      = ST_CHECK;
            end
            ST_CHECK: begin
                if (stat.cur_func == lpim_pkg::FUNC_INSERT) begin
                    if (stat.slot_empty) begin
                        cmd.ins_write  = 1'b1;
                        cmd.res_load   = 1'b1;
                        cmd.res_status = lpim_pkg::STAT_OK;
                        cmd.res_sel    = lpim_pkg::MAP_COUNT;
                        state_next     = ST_DONE;
                    end else if (stat.probe_last) begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = lpim_pkg::STAT_FULL;
                        cmd.res_sel    = lpim_pkg::MAP_ZERO;
                        state_next     = ST_DONE;
                    end else begin
                        cmd.probe_step = 1'b1;
                    end
                end else begin
                    if (stat.slot_hit) begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = lpim_pkg::STAT_OK;
                        cmd.res_sel    = lpim_pkg::MAP_SLOT;
                        state_next     = ST_DONE;
                    end else if (stat.slot_empty || stat.probe_last) begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = lpim_pkg::STAT_NOT_FOUND;
                        cmd.res_sel    = lpim_pkg::MAP_ZERO;
                        state_next     = ST_DONE;
                    end else begin
                        cmd.probe_step = 1'b1;
                    end
                end
            end
            ST_SWEEP: begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last) begin
                    cmd.clear_load = 1'b1;
                    cmd.res_load   = 1'b1;
                    cmd.res_status = lpim_pkg::STAT_OK;
                    cmd.res_sel    = lpim_pkg::MAP_ZERO;
                    state_next     = ST_DONE;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.push_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/linear_probe_id_map.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_id_map
// Open-addressed hash table that maps a node key to a densely numbered id.
//
// Input items (s_ channel) carry a function code and a key: lookup, insert
// or clear. Each item gives exactly one result item on the m_ channel with a
// status, the mapped id and the id counter value after the item.
// The cfg channel writes table_size (index 0) and first_value (index 1); it is
// always ready; the user writes it only while no item is in flight, and the block does not enforce this.
//
// A lookup or insert first runs the bit-serial key modulo table size divider,
// then probes slots from that remainder, one per cycle, until it has its result.
// A clear does one memory write per slot.
// One item is worked on at a time; the next is taken once the result is in
// the output register, so a stalled receiver holds one finished item while
// the next one is processed, and stops the block after that.
// After reset the slot memory is swept with s_tready low; config writes are
// taken during that sweep.
// ----------------------------------------------------------------------------
module linear_probe_id_map #(
    parameter int CAPACITY  = 1024,
    parameter int KEY_WIDTH = 24,
    parameter int ID_WIDTH  = 24
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lpim_pkg::S_TDATA_W-1:0]    s_tdata,   // func, key
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lpim_pkg::M_TDATA_W-1:0]    m_tdata,   // status, mapped_id, next_id
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lpim_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [lpim_pkg::CFG_DATA_W-1:0]   cfg_data
);

    lpim_pkg::cmd_t  cmd;
    lpim_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    lpim_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_func   (s_tdata[lpim_pkg::FUNC_W-1:0]),
        .stat     (stat),
        .cmd      (cmd)
    );

    lpim_datapath #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH),
        .ID_WIDTH  (ID_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

// ----- hw/rtl/lpim_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpim_checker
// Port-level checks on the linear probe id map, bound to the top level.
// ----------------------------------------------------------------------------
module lpim_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [lpim_pkg::M_TDATA_W-1:0] m_tdata
);

    // result held while stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // no input ready right after reset, at the start of the post-reset memory sweep
    assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready right after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("undefined status code");

    // failed lookup or full table gives id zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != lpim_pkg::STAT_OK) |-> m_tdata[25:2] == 24'd0)
        else $error("nonzero id with error status");

endmodule

bind linear_probe_id_map lpim_checker u_lpim_checker (.*);
